### hdl/ptw_pkg.sv
// Shared types and constants for the power-of-two timeout wheel.
package ptw_pkg;

  // Default sizes of the wheel.
  localparam int NUM_SLOTS_DEF = 16;
  localparam int ORDER_MAX_DEF = 8;

  // Fixed field widths.
  localparam int TICK_W = 32;
  localparam int SLOT_W = 4;

  // Function codes of an input transaction.
  localparam logic FUNC_SET  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_EMIT
  } ptw_state_e;

endpackage

### hdl/ptw_ram.sv
// Generic simple dual-port RAM with registered read.
module ptw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/ptw_file_unit.sv
// Shared add/subtract unit with bucket classification of a tick count.
module ptw_file_unit #(
  parameter int ORDER_MAX = ptw_pkg::ORDER_MAX_DEF,
  localparam int CODE_W = $clog2(2 * ORDER_MAX),
  localparam int OW = $clog2(ORDER_MAX)
) (
  input  logic [ptw_pkg::TICK_W-1:0] a_i,
  input  logic [ptw_pkg::TICK_W-1:0] b_i,
  input  logic                       sub_i,
  input  logic [ORDER_MAX-1:0]       parity_i,
  output logic [ptw_pkg::TICK_W-1:0] sum_o,
  output logic                       zero_o,
  output logic                       due_o,
  output logic [CODE_W-1:0]          code_o
);

  logic [ptw_pkg::TICK_W-1:0] b_x;
  logic [ptw_pkg::TICK_W-1:0] class_v;
  logic [OW-1:0]              ord;

  // One adder: a + b when filing a new timeout, a - b when refiling.
  assign b_x   = sub_i ? ~b_i : b_i;
  assign sum_o = a_i + b_x + ptw_pkg::TICK_W'(sub_i);

  // The count to classify is the input tick count or the remaining ticks.
  assign class_v = sub_i ? sum_o : b_i;
  assign zero_o  = (class_v == '0);

  // Deadline equals the clock or lies one tick behind it.
  assign due_o = (sum_o == '0) || (sum_o == '1);

  // Highest order whose doubled power the count reaches.
  always_comb begin
    ord = '0;
    for (int k = 1; k < ORDER_MAX; k++) begin
      if ((class_v >> (k + 1)) != '0) begin
        ord = OW'(k);
      end
    end
  end

  // Inactive half in either case: the lower half when the order's parity bit is set, the upper half otherwise.
  assign code_o = parity_i[ord] ? CODE_W'(ord) : CODE_W'(ord) + CODE_W'(ORDER_MAX);

endmodule

### hdl/power_of_two_timeout_wheel_unit.sv
// Top level of the power-of-two timeout wheel: sequencer, slot state and result port.
//
// A set-timeout transaction (func_i = 0) is taken while idle and busy never
// rises for it. A tick transaction (func_i = 1) keeps busy high while it
// walks T orders, where T is the number of clock bits below ORDER_MAX that
// toggle (one on half of all ticks, at most ORDER_MAX), and then while the
// abort scan runs: it ends at once when nothing is aborted, otherwise after
// the highest aborted slot, and at the latest after the last slot. Every slot
// of each walked order passes a read and an evaluate state on the one read
// port of the slot RAM, through the one shared adder and classifier, and the
// aborts are then sent out in a slot scan.
// Aborts appear on aborted_slot_o and last_o for exactly one cycle each,
// marked by strobe_o, in ascending slot order, with last_o set on the final
// abort of the tick. The receiver cannot stall the results, and a tick that
// aborts nothing produces no transaction.
module power_of_two_timeout_wheel_unit #(
  parameter int NUM_SLOTS = ptw_pkg::NUM_SLOTS_DEF,
  parameter int ORDER_MAX = ptw_pkg::ORDER_MAX_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       func_i,
  input  logic [ptw_pkg::SLOT_W-1:0] slot_i,
  input  logic [ptw_pkg::TICK_W-1:0] ticks_i,
  output logic                       strobe_o,
  output logic [ptw_pkg::SLOT_W-1:0] aborted_slot_o,
  output logic                       last_o
);

  localparam int SW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int OW     = $clog2(ORDER_MAX);
  localparam int CODE_W = $clog2(2 * ORDER_MAX);
  localparam int TW     = ptw_pkg::TICK_W;
  localparam int ENT_W  = CODE_W + TW;

  ptw_pkg::ptw_state_e state_q, state_d;

  logic [TW-1:0]             clock_q, clock_d;
  logic [ORDER_MAX-1:0]      parity_q, parity_d;
  logic [ORDER_MAX-1:0]      toggled_q, toggled_d;
  logic [NUM_SLOTS-1:0]      armed_q, armed_d;
  logic [NUM_SLOTS-1:0]      aborted_q, aborted_d;
  logic [OW-1:0]             order_q, order_d;
  logic [SW-1:0]             idx_q, idx_d;
  logic                      strobe_q, strobe_d;
  logic [ptw_pkg::SLOT_W-1:0] out_slot_q, out_slot_d;
  logic                      last_q, last_d;

  logic [TW-1:0]    clock_inc;
  logic [TW-1:0]    slot_ext;
  logic             slot_ok;
  logic             accept;

  logic             ram_we;
  logic [SW-1:0]    ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [ENT_W-1:0] ram_rdata;
  logic [CODE_W-1:0] rd_code;
  logic [TW-1:0]    rd_deadline;

  logic [TW-1:0]     unit_a, unit_b, unit_sum;
  logic              unit_sub, unit_zero, unit_due;
  logic [CODE_W-1:0] unit_code;

  logic [CODE_W-1:0]    walk_code;
  logic                 last_slot, last_order;
  logic [NUM_SLOTS-1:0] idx_onehot;

  // Slot entries: bucket code over deadline.
  ptw_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign rd_code     = ram_rdata[ENT_W-1:TW];
  assign rd_deadline = ram_rdata[TW-1:0];

  // Shared arithmetic: deadline on a set, remaining ticks on a refile.
  assign unit_sub = (state_q != ptw_pkg::ST_IDLE);
  assign unit_a   = unit_sub ? rd_deadline : clock_q;
  assign unit_b   = unit_sub ? clock_q : ticks_i;

  ptw_file_unit #(
    .ORDER_MAX (ORDER_MAX)
  ) u_file_unit (
    .a_i      (unit_a),
    .b_i      (unit_b),
    .sub_i    (unit_sub),
    .parity_i (parity_q),
    .sum_o    (unit_sum),
    .zero_o   (unit_zero),
    .due_o    (unit_due),
    .code_o   (unit_code)
  );

  // Handshake and helper terms.
  assign busy       = (state_q != ptw_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign clock_inc  = clock_q + TW'(1);
  assign slot_ext   = TW'(slot_i);
  assign slot_ok    = (slot_ext < TW'(NUM_SLOTS));
  assign walk_code  = parity_q[order_q] ? (CODE_W'(order_q) + CODE_W'(ORDER_MAX))
                                        : CODE_W'(order_q);
  assign last_slot  = (idx_q == SW'(NUM_SLOTS - 1));
  assign last_order = (order_q == OW'(ORDER_MAX - 1)) || !toggled_q[OW'(order_q + 1'b1)];
  assign idx_onehot = NUM_SLOTS'(1) << idx_q;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptw_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control and status registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q   <= '0;
      parity_q  <= '0;
      toggled_q <= '0;
      armed_q   <= '0;
      aborted_q <= '0;
      order_q   <= '0;
      idx_q     <= '0;
      strobe_q  <= 1'b0;
    end else begin
      clock_q   <= clock_d;
      parity_q  <= parity_d;
      toggled_q <= toggled_d;
      armed_q   <= armed_d;
      aborted_q <= aborted_d;
      order_q   <= order_d;
      idx_q     <= idx_d;
      strobe_q  <= strobe_d;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    out_slot_q <= out_slot_d;
    last_q     <= last_d;
  end

  // Next state, slot updates and result generation.
  always_comb begin
    state_d    = state_q;
    clock_d    = clock_q;
    parity_d   = parity_q;
    toggled_d  = toggled_q;
    armed_d    = armed_q;
    aborted_d  = aborted_q;
    order_d    = order_q;
    idx_d      = idx_q;
    strobe_d   = 1'b0;
    out_slot_d = out_slot_q;
    last_d     = last_q;
    ram_we     = 1'b0;
    ram_waddr  = idx_q;
    ram_wdata  = {unit_code, rd_deadline};

    case (state_q)
      ptw_pkg::ST_IDLE: begin
        if (accept && (func_i == ptw_pkg::FUNC_SET)) begin
          // File the slot, or disarm it on a zero count.
          if (slot_ok) begin
            ram_we    = !unit_zero;
            ram_waddr = slot_ext[SW-1:0];
            ram_wdata = {unit_code, unit_sum};
            armed_d[slot_ext[SW-1:0]] = !unit_zero;
          end
        end else if (accept) begin
          // Advance the clock and start the walk at order zero.
          clock_d   = clock_inc;
          toggled_d = clock_q[ORDER_MAX-1:0] ^ clock_inc[ORDER_MAX-1:0];
          aborted_d = '0;
          order_d   = '0;
          idx_d     = '0;
          state_d   = ptw_pkg::ST_READ;
        end
      end

      ptw_pkg::ST_READ: begin
        state_d = ptw_pkg::ST_EVAL;
      end

      ptw_pkg::ST_EVAL: begin
        // A slot in the walked bucket is aborted when due, else refiled.
        if (armed_q[idx_q] && (rd_code == walk_code)) begin
          if (unit_due) begin
            armed_d[idx_q]   = 1'b0;
            aborted_d[idx_q] = 1'b1;
          end else begin
            ram_we = 1'b1;
          end
        end
        if (!last_slot) begin
          idx_d   = idx_q + SW'(1);
          state_d = ptw_pkg::ST_READ;
        end else begin
          parity_d[order_q] = !parity_q[order_q];
          idx_d             = '0;
          if (last_order) begin
            state_d = ptw_pkg::ST_EMIT;
          end else begin
            order_d = order_q + OW'(1);
            state_d = ptw_pkg::ST_READ;
          end
        end
      end

      ptw_pkg::ST_EMIT: begin
        // Send aborts in ascending slot order.
        if (aborted_q == '0) begin
          state_d = ptw_pkg::ST_IDLE;
        end else begin
          if (aborted_q[idx_q]) begin
            strobe_d         = 1'b1;
            out_slot_d       = ptw_pkg::SLOT_W'(idx_q);
            last_d           = ((aborted_q & ~idx_onehot) == '0);
            aborted_d[idx_q] = 1'b0;
          end
          if (last_slot) begin
            state_d = ptw_pkg::ST_IDLE;
          end else begin
            idx_d = idx_q + SW'(1);
          end
        end
      end

      default: begin
        state_d = ptw_pkg::ST_IDLE;
      end
    endcase
  end

  assign strobe_o       = strobe_q;
  assign aborted_slot_o = out_slot_q;
  assign last_o         = last_q;

endmodule
